// ===== sv/morse_edge_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the morse edge decoder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MORSE_EDGE_DECODER_CORE_ASSERT_SVH
`define MORSE_EDGE_DECODER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/med_pkg.sv =====
// ----------------------------------------------------------------------------
// med_pkg
// Shared types, constants and the symbol ROM of the morse edge decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package med_pkg;

  localparam int STAMP_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int GLYPH_W   = 7;
  localparam int ROM_SIZE  = 43;
  localparam int ROM_IDX_W = 6;
  localparam int PAT_W     = 8;   // widest symbol the buffer may hold
  localparam int LEN_W     = 4;

  localparam logic [GLYPH_W-1:0] GLYPH_BASE = 7'h30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_MIN    = 3'd0,
    REG_DOT_MAX    = 3'd1,
    REG_DASH_MIN   = 3'd2,
    REG_DASH_MAX   = 3'd3,
    REG_LETTER_GAP = 3'd4
  } med_reg_e;

  localparam logic [CFG_W-1:0] DOT_MIN_RST    = 16'd1100;
  localparam logic [CFG_W-1:0] DOT_MAX_RST    = 16'd1400;
  localparam logic [CFG_W-1:0] DASH_MIN_RST   = 16'd3200;
  localparam logic [CFG_W-1:0] DASH_MAX_RST   = 16'd4000;
  localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd2500;

  // commands from the front end to the symbol back end
  typedef enum logic [1:0] {
    OP_DOT  = 2'd0,
    OP_DASH = 2'd1,
    OP_END  = 2'd2
  } med_op_e;

  typedef struct packed {
    med_op_e op;
  } med_cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } med_cfg_wr_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               status;
  } med_res_t;

  // symbol ROM: element count and pattern, element k in bit k, dash = 1
  localparam logic [LEN_W-1:0] ROM_LEN [ROM_SIZE] = '{
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd0, 4'd5, 4'd0, 4'd6,
    4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3,
    4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };

  localparam logic [PAT_W-1:0] ROM_PAT [ROM_SIZE] = '{
    8'h1F, 8'h1E, 8'h1C, 8'h18, 8'h10, 8'h00, 8'h01, 8'h03,
    8'h07, 8'h0F, 8'h07, 8'h15, 8'h00, 8'h11, 8'h00, 8'h0C,
    8'h16, 8'h02, 8'h01, 8'h05, 8'h01, 8'h00, 8'h04, 8'h03, 8'h00, 8'h00,
    8'h0E, 8'h05, 8'h02, 8'h03, 8'h01, 8'h07, 8'h06, 8'h0B, 8'h02, 8'h00,
    8'h01, 8'h04, 8'h08, 8'h06, 8'h09, 8'h0D, 8'h03
  };

endpackage

`default_nettype wire

// ===== sv/med_fifo.sv =====
// ----------------------------------------------------------------------------
// med_fifo
// Small register FIFO with fall-through read, used for commands and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module med_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2   // power of two
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/med_front.sv =====
// ----------------------------------------------------------------------------
// med_front
// Edge front end: holds the timing registers, measures marks and gaps and
// turns accepted stamps into dot, dash or end-of-symbol commands where they qualify.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module med_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  med_pkg::med_cfg_wr_t        cfg_i,
  input  logic                        push_i,
  input  logic [med_pkg::STAMP_W-1:0] stamp_i,
  input  logic                        cmd_full_i,
  output logic                        cmd_push_o,
  output med_pkg::med_cmd_t           cmd_o
);

  import med_pkg::*;

  localparam int TW = TIMER_BITS;
  localparam int SW = (TW < STAMP_W) ? TW : STAMP_W;
  localparam int CW = (TW > CFG_W) ? TW : CFG_W;

  logic [CFG_W-1:0] dot_min_q, dot_max_q, dash_min_q, dash_max_q, letter_gap_q;
  logic             await_fall_q, gap_valid_q;
  logic [TW-1:0]    rise_q, fall_q;

  logic             accept;
  logic [TW-1:0]    t, mark, gap;
  logic [CW-1:0]    mark_x, gap_x;
  logic             is_dot, is_dash, is_end;

  assign accept = push_i && !cmd_full_i;

  // stamp reduced to the timer width, differences wrap
  always_comb begin
    t         = '0;
    t[SW-1:0] = stamp_i[SW-1:0];
  end

  assign mark = t - rise_q;
  assign gap  = t - fall_q;

  always_comb begin
    mark_x         = '0;
    gap_x          = '0;
    mark_x[TW-1:0] = mark;
    gap_x[TW-1:0]  = gap;
  end

  // mark and gap classification against the windows
  assign is_dot  = (mark_x > CW'(dot_min_q)) && (mark_x < CW'(dot_max_q));
  assign is_dash = !is_dot && (mark_x > CW'(dash_min_q)) && (mark_x < CW'(dash_max_q));
  assign is_end  = gap_valid_q && (gap_x > CW'(letter_gap_q));

  // command to the back end
  always_comb begin
    cmd_push_o = 1'b0;
    cmd_o.op   = OP_END;
    if (accept) begin
      if (!await_fall_q) begin
        cmd_push_o = is_end;
      end else if (is_dot) begin
        cmd_push_o = 1'b1;
        cmd_o.op   = OP_DOT;
      end else if (is_dash) begin
        cmd_push_o = 1'b1;
        cmd_o.op   = OP_DASH;
      end
    end
  end

  // edge tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_fall_q <= 1'b0;
      gap_valid_q  <= 1'b0;
      rise_q       <= '0;
      fall_q       <= '0;
    end else if (accept) begin
      await_fall_q <= !await_fall_q;
      if (!await_fall_q) begin
        rise_q <= t;
      end else begin
        fall_q      <= t;
        gap_valid_q <= 1'b1;
      end
    end
  end

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_min_q    <= DOT_MIN_RST;
      dot_max_q    <= DOT_MAX_RST;
      dash_min_q   <= DASH_MIN_RST;
      dash_max_q   <= DASH_MAX_RST;
      letter_gap_q <= LETTER_GAP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DOT_MIN:    dot_min_q    <= cfg_i.data;
        REG_DOT_MAX:    dot_max_q    <= cfg_i.data;
        REG_DASH_MIN:   dash_min_q   <= cfg_i.data;
        REG_DASH_MAX:   dash_max_q   <= cfg_i.data;
        REG_LETTER_GAP: letter_gap_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/med_back.sv =====
// ----------------------------------------------------------------------------
// med_back
// Symbol back end: collects elements, and on end of symbol looks the pattern
// up in the ROM and, if anything was held, hands one word to the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module med_back #(
  parameter int MAX_ELEMENTS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  med_pkg::med_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output med_pkg::med_res_t  res_o
);

  import med_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  logic [CNT_W-1:0]        count_q, count_d;
  logic [MAX_ELEMENTS-1:0] bits_q, bits_d;
  logic                    too_long_q, too_long_d;

  logic [PAT_W-1:0]        bits_x;
  logic [LEN_W-1:0]        count_x;
  logic                    found;
  logic [ROM_IDX_W-1:0]    hit_idx;

  always_comb begin
    bits_x                    = '0;
    count_x                   = '0;
    bits_x[MAX_ELEMENTS-1:0]  = bits_q;
    count_x[CNT_W-1:0]        = count_q;
  end

  // ROM search, lowest matching index wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (!found && (ROM_LEN[i] == count_x) && (ROM_PAT[i] == bits_x)
          && (count_x != '0)) begin
        found   = 1'b1;
        hit_idx = ROM_IDX_W'(i);
      end
    end
  end

  // command execution
  always_comb begin
    count_d      = count_q;
    bits_d       = bits_q;
    too_long_d   = too_long_q;
    res_push_o   = 1'b0;
    res_o.glyph  = '0;
    res_o.status = 1'b1;
    cmd_pop_o    = cmd_valid_i && !res_full_i;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_DOT, OP_DASH: begin
          if (count_q < CNT_W'(MAX_ELEMENTS)) begin
            bits_d[count_q[IDX_W-1:0]] = (cmd_i.op == OP_DASH);
            count_d = count_q + 1'b1;
          end else begin
            too_long_d = 1'b1;
          end
        end
        OP_END: begin
          res_push_o = (count_q != '0) || too_long_q;
          if (!too_long_q && found) begin
            res_o.glyph  = GLYPH_BASE + GLYPH_W'(hit_idx);
            res_o.status = 1'b0;
          end
          count_d    = '0;
          bits_d     = '0;
          too_long_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      bits_q     <= '0;
      too_long_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      bits_q     <= bits_d;
      too_long_q <= too_long_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/morse_edge_decoder_core.sv =====
// ----------------------------------------------------------------------------
// morse_edge_decoder_core
// Decodes morse characters from timer capture stamps of a keyed signal.
// ----------------------------------------------------------------------------
// Takes one edge stamp per clock while full is low; one character word can be
// taken per clock from the result side. A stamp that finishes a symbol is
// registered as a command in the queue between the edge front end and the
// symbol back end; the back end then writes its word into the result queue,
// from which it shows on the result ports. Each side stalls on its own;
// stamps are held off while the two-entry command queue is full, which can
// only happen once the two-entry result queue has backed up. Status 1 marks
// an unknown or overlong pattern, with glyph zero.
`timescale 1ns / 1ps
`default_nettype none

module morse_edge_decoder_core #(
  parameter int MAX_ELEMENTS = 6,
  parameter int TIMER_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [med_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [med_pkg::CFG_W-1:0]     cfg_data_i,
  // stamps in
  input  logic                          push,
  output logic                          full,
  input  logic [med_pkg::STAMP_W-1:0]   stamp_i,
  // characters out
  output logic                          empty,
  input  logic                          pop,
  output logic [med_pkg::GLYPH_W-1:0]   glyph_o,
  output logic                          status_o
);

  import med_pkg::*;

  `include "morse_edge_decoder_core_assert.svh"

  med_cfg_wr_t cfg_wr;
  logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
  med_cmd_t    cmd_in, cmd_out;
  logic        res_push, res_full;
  med_res_t    res_in, res_out;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // edge front end
  med_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .push_i     (push),
    .stamp_i    (stamp_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  assign full = cmd_full;

  // command queue
  med_fifo #(
    .DATA_W ($bits(med_cmd_t)),
    .DEPTH  (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // symbol back end
  med_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  med_fifo #(
    .DATA_W ($bits(med_res_t)),
    .DEPTH  (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign glyph_o  = res_out.glyph;
  assign status_o = res_out.status;

  // checks
  `MED_ASSERT_NOW(a_res_no_drop, res_push, !res_full, "result pushed into a full queue")
  `MED_ASSERT_NEXT(a_res_visible, res_push, !empty, "pushed result not visible")
  `MED_ASSERT_NOW(a_unknown_zero, !empty && status_o, glyph_o == '0, "unknown word with glyph")
  `MED_ASSERT_NOW(a_glyph_range, !empty && !status_o, (glyph_o >= 7'h30) && (glyph_o <= 7'h5A), "decoded glyph out of range")

endmodule

`default_nettype wire

// ===== tb/sv/morse_edge_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// morse_edge_decoder_core_tb
// Self-checking bench for the morse edge decoder core.
// ----------------------------------------------------------------------------
// Edge stamps are keyed into the decoder as well-formed symbols with
// random timing, broken symbols and stray stamps. The register set is changed
// between phases, extremes included. A model of the edge decoder runs on each
// accepted stamp and queues the character word it should give; every word
// popped from the result side is checked against the oldest queued word.
`timescale 1ns / 1ps

module morse_edge_decoder_core_tb;
  import med_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_MARKS   = 6;
  localparam int SETTLE_CYC  = 4;
  // register indexes past the end of the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {MARK_DOT, MARK_DASH, MARK_STRAY} mark_kind_e;

  typedef struct {
    logic [GLYPH_W-1:0] glyph;
    logic               status;
  } char_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 push;
  logic                 full;
  logic [STAMP_W-1:0]   stamp_i;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [GLYPH_W-1:0]   glyph_o;
  logic                 status_o;

  morse_edge_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .stamp_i     (stamp_i),
    .empty       (empty),
    .pop         (pop),
    .glyph_o     (glyph_o),
    .status_o    (status_o)
  );

  // symbol table, ASCII 0x30 upwards; the two blank entries never match
  string morse_tab [ROM_SIZE] = '{
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----.", "---...", "-.-.-.", "", "-...-", "", "..--..",
    ".--.-.", ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...",
    "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  // decoder model state and register copy
  logic [CFG_W-1:0]   dot_lo, dot_hi, dash_lo, dash_hi, gap_lim;
  logic               exp_fall, seen_fall, overlong;
  logic [STAMP_W-1:0] last_rise, last_fall;
  int                 n_elems;
  logic [5:0]         elem_pat;

  char_word_t         pending_chars [$];
  int                 mismatches  = 0;
  int                 stamps_sent = 0;
  int                 cycles      = 0;
  logic [STAMP_W-1:0] tnow        = '0;
  bit                 feed_gaps   = 1'b1;
  bit                 drain_stalls = 1'b1;
  int                 pop_hold    = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // ROM index of the held symbol, -1 when nothing matches
  function automatic int rom_index(input int n, input logic [5:0] pat);
    string s;
    bit    same;
    for (int i = 0; i < ROM_SIZE; i++) begin
      s = morse_tab[i];
      if (s.len() == n && n > 0) begin
        same = 1'b1;
        for (int k = 0; k < n; k++)
          if ((s[k] == "-") != pat[k]) same = 1'b0;
        if (same) return i;
      end
    end
    return -1;
  endfunction

  task automatic model_reset();
    dot_lo    = DOT_MIN_RST;
    dot_hi    = DOT_MAX_RST;
    dash_lo   = DASH_MIN_RST;
    dash_hi   = DASH_MAX_RST;
    gap_lim   = LETTER_GAP_RST;
    exp_fall  = 1'b0;
    seen_fall = 1'b0;
    overlong  = 1'b0;
    last_rise = '0;
    last_fall = '0;
    n_elems   = 0;
    elem_pat  = '0;
  endtask

  task automatic add_element(input logic is_dash);
    if (n_elems < MAX_MARKS) begin
      elem_pat[n_elems] = is_dash;
      n_elems++;
    end else begin
      overlong = 1'b1;
    end
  endtask

  // model step for one accepted stamp
  task automatic predict_edge(input logic [STAMP_W-1:0] t);
    logic [STAMP_W-1:0] span;
    int                 idx;
    char_word_t         w;
    if (!exp_fall) begin
      // rising edge: a long enough gap closes the symbol
      if (seen_fall) begin
        span = t - last_fall;
        if (span > gap_lim && (n_elems > 0 || overlong)) begin
          idx = overlong ? -1 : rom_index(n_elems, elem_pat);
          if (idx >= 0) begin
            w.glyph  = GLYPH_BASE + 7'(idx);
            w.status = 1'b0;
          end else begin
            w.glyph  = '0;
            w.status = 1'b1;
          end
          pending_chars.push_back(w);
          n_elems  = 0;
          elem_pat = '0;
          overlong = 1'b0;
        end
      end
      last_rise = t;
      exp_fall  = 1'b1;
    end else begin
      // falling edge: classify the mark
      span = t - last_rise;
      if (span > dot_lo && span < dot_hi) add_element(1'b0);
      else if (span > dash_lo && span < dash_hi) add_element(1'b1);
      last_fall = t;
      seen_fall = 1'b1;
      exp_fall  = 1'b0;
    end
  endtask

  // result side: random pop stalls in bursts
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold--;
    end else if (drain_stalls && $urandom_range(0, 5) == 0) begin
      pop = 1'b0;
      pop_hold = $urandom_range(0, 3);
    end else begin
      pop = 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    char_word_t w;
    if (rst_ni && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected: glyph %02h status %0b",
                                  glyph_o, status_o));
      end else begin
        w = pending_chars.pop_front();
        if (glyph_o !== w.glyph)
          report_mismatch($sformatf("glyph %02h, expected %02h", glyph_o, w.glyph));
        if (status_o !== w.status)
          report_mismatch($sformatf("status %0b, expected %0b", status_o, w.status));
      end
    end
  end

  // one stamp into the decoder, called and returning at a falling edge
  task automatic send_stamp(input logic [STAMP_W-1:0] s);
    if (feed_gaps && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push    = 1'b1;
    stamp_i = s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_edge(s);
    tnow = s;
    stamps_sent++;
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic edge_after(input logic [STAMP_W-1:0] delta);
    send_stamp(tnow + delta);
  endtask

  // let every expected word drain, then allow the pipe to settle
  task automatic wait_quiet();
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_DOT_MIN:    dot_lo  = val;
      REG_DOT_MAX:    dot_hi  = val;
      REG_DASH_MIN:   dash_lo = val;
      REG_DASH_MAX:   dash_hi = val;
      REG_LETTER_GAP: gap_lim = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_windows(input logic [CFG_W-1:0] dmin, dmax, hmin, hmax, gap);
    wait_quiet();
    write_reg(REG_DOT_MIN, dmin);
    write_reg(REG_DOT_MAX, dmax);
    write_reg(REG_DASH_MIN, hmin);
    write_reg(REG_DASH_MAX, hmax);
    write_reg(REG_LETTER_GAP, gap);
  endtask

  // length strictly inside (lo, hi), now and then a bound, any if none fits
  function automatic logic [STAMP_W-1:0] pick_open(input logic [CFG_W-1:0] lo, hi);
    int l;
    int h;
    int r;
    l = int'(lo);
    h = int'(hi);
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (h - l < 2) return STAMP_W'($urandom_range(0, 65535));
    if (r == 2) return STAMP_W'(l + 1);
    if (r == 3) return STAMP_W'(h - 1);
    return STAMP_W'($urandom_range(l + 1, h - 1));
  endfunction

  function automatic logic [STAMP_W-1:0] long_gap();
    if (gap_lim == '1) return STAMP_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 5) == 0) return gap_lim + 1'b1;
    return STAMP_W'($urandom_range(int'(gap_lim) + 1, 65535));
  endfunction

  function automatic logic [STAMP_W-1:0] short_gap();
    if ($urandom_range(0, 5) == 0) return gap_lim;
    return STAMP_W'($urandom_range(0, int'(gap_lim)));
  endfunction

  function automatic logic [STAMP_W-1:0] mark_len(input mark_kind_e kind);
    case (kind)
      MARK_DOT:  return pick_open(dot_lo, dot_hi);
      MARK_DASH: return pick_open(dash_lo, dash_hi);
      default:   return STAMP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one keyed symbol; the long gap in front closes whatever is held
  task automatic key_symbol(input int n, input bit broken);
    int         r;
    mark_kind_e kind;
    if (exp_fall) edge_after(STAMP_W'($urandom_range(0, 65535)));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      kind = (r < 9) ? MARK_DOT : (r < 18) ? MARK_DASH : MARK_STRAY;
      if (k == 0) edge_after(long_gap());
      else if (broken) edge_after(STAMP_W'($urandom_range(0, 65535)));
      else edge_after(short_gap());
      edge_after(mark_len(kind));
    end
  endtask

  // mostly well-formed symbols, some broken ones and stray stamps
  task automatic run_traffic(input int items);
    int stop;
    int r;
    int n;
    stop = stamps_sent + items;
    while (stamps_sent < stop) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        n = $urandom_range(0, 15);
        n = (n < 12) ? $urandom_range(1, 6) : (n < 14) ? $urandom_range(7, 8) : 0;
        key_symbol(n, r == 7);
      end else begin
        repeat ($urandom_range(1, 4)) send_stamp(STAMP_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  // reset values: A, an ignored mark, an empty symbol, an overlong symbol
  // across the timer wrap, then the window and gap bounds themselves
  task automatic test_directed_defaults();
    send_stamp(16'h0000);          // first rise, no gap measured
    edge_after(16'd1200);          // dot
    edge_after(16'd300);
    edge_after(16'd3500);          // dash
    edge_after(16'd3000);          // closes A
    edge_after(16'd500);           // too short, ignored
    send_stamp(16'hFFFF);          // long gap, nothing held
    for (int k = 0; k < 7; k++) begin
      if (k > 0) edge_after(16'd300);
      edge_after(16'd1250);        // first one wraps the timer
    end
    edge_after(16'd3000);          // closes the overlong symbol
    edge_after(DOT_MAX_RST);       // on the bound, ignored
    edge_after(LETTER_GAP_RST);    // gap on the bound, symbol stays open
    edge_after(DASH_MIN_RST + 1'b1);
    edge_after(LETTER_GAP_RST + 1'b1);
  endtask

  task automatic test_traffic_defaults();
    run_traffic(200);
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] dmin, dmax, hmin, hmax;
    dmin = CFG_W'($urandom_range(0, 3000));
    dmax = dmin + CFG_W'($urandom_range(2, 1500));
    hmin = dmax + CFG_W'($urandom_range(0, 2000));
    hmax = hmin + CFG_W'($urandom_range(2, 3000));
    load_windows(dmin, dmax, hmin, hmax, CFG_W'($urandom_range(500, 6000)));
    run_traffic(150);
  endtask

  // every mark inside (0, FFFF) a dot and every nonzero gap a symbol end
  task automatic test_wide_windows();
    load_windows(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    run_traffic(80);
  endtask

  // no dot window, symbols never close, so the buffer overruns
  task automatic test_closed_windows();
    wait_quiet();
    write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, CFG_W'($urandom_range(0, 65535)));
    load_windows(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_traffic(40);
  endtask

  // closing part without idling on either side
  task automatic test_final_burst();
    logic [CFG_W-1:0] dmin, dmax, hmin, hmax;
    dmin = CFG_W'($urandom_range(200, 2000));
    dmax = dmin + CFG_W'($urandom_range(2, 800));
    hmin = dmax + CFG_W'($urandom_range(0, 1000));
    hmax = hmin + CFG_W'($urandom_range(2, 2000));
    load_windows(dmin, dmax, hmin, hmax, CFG_W'($urandom_range(100, 4000)));
    feed_gaps    = 1'b0;
    drain_stalls = 1'b0;
    run_traffic(155);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DOT_MIN;
    cfg_data_i  = '0;
    push        = 1'b0;
    stamp_i     = '0;
    model_reset();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_defaults();
    test_traffic_defaults();
    test_random_windows();
    test_wide_windows();
    test_closed_windows();
    test_final_burst();

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
